// ----- rtl/core/bgra_anp_pkg.sv -----
// ----------------------------------------------------------------------------
// bgra_anp_pkg
// Shared types and constants for the bgra alpha normalize / premultiply block.
// ----------------------------------------------------------------------------
package bgra_anp_pkg;

  localparam int unsigned MaxPixels = 262144;
  localparam int unsigned IdxW      = $clog2(MaxPixels);
  localparam int unsigned DimW      = 10;
  localparam int unsigned LimW      = 2 * DimW;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned QDepth    = 4;
  localparam int unsigned QPtrW     = $clog2(QDepth);

  localparam logic [DimW-1:0] DimLimit  = DimW'(512);
  localparam logic [7:0]      AlphaFull = 8'hFF;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_LOAD  = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MODE_FORCED = 2'd0,
    MODE_OPAQUE = 2'd1,
    MODE_PREMUL = 2'd2,
    MODE_SCALED = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_ERR   = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_MUL,
    BK_OUT
  } back_state_e;

  typedef struct packed {
    op_e             opcode;
    logic [IdxW-1:0] pixel_index;
    logic [31:0]     pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] pixel_out;
    mode_e       alpha_mode;
    logic        index_error;
  } out_item_t;

  typedef struct packed {
    cmd_kind_e       kind;
    mode_e           mode;
    logic [IdxW-1:0] index;
    logic [31:0]     pixel;
  } cmd_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

// ----- rtl/core/bgra_anp_front.sv -----
// ----------------------------------------------------------------------------
// bgra_anp_front
// Takes input items, checks the index, keeps the whole-image alpha flags and
// turns each load or read item into a command for the back end.
// ----------------------------------------------------------------------------
module bgra_anp_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  bgra_anp_pkg::in_item_t              in_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bgra_anp_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [bgra_anp_pkg::DimW-1:0]       cfg_data_i,
  input  bgra_anp_pkg::q_stat_t               q_stat_i,
  output logic                                push_o,
  output bgra_anp_pkg::cmd_t                  cmd_o
);
  import bgra_anp_pkg::*;

  logic [DimW-1:0] width_q, height_q;
  logic            seen_nz_q, seen_nz_d;
  logic            all_full_q, all_full_d;
  logic            exceeds_q, exceeds_d;
  logic [DimW-1:0] w_sat, h_sat;
  logic [LimW-1:0] limit;
  logic            bad_idx;
  logic            accept;
  logic [7:0]      a_in;
  mode_e           cur_mode;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_stat_i.full;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DimLimit;
      height_q <= DimLimit;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_WIDTH)  width_q  <= cfg_data_i;
      if (cfg_index_i == REG_HEIGHT) height_q <= cfg_data_i;
    end
  end

  assign w_sat   = (width_q  > DimLimit) ? DimLimit : width_q;
  assign h_sat   = (height_q > DimLimit) ? DimLimit : height_q;
  assign limit   = LimW'(w_sat) * LimW'(h_sat);
  assign bad_idx = {{(LimW-IdxW){1'b0}}, in_i.pixel_index} >= limit;
  assign a_in    = in_i.pixel_in[31:24];

  always_comb begin
    priority if (!seen_nz_q) cur_mode = MODE_FORCED;
    else if (all_full_q)     cur_mode = MODE_OPAQUE;
    else if (!exceeds_q)     cur_mode = MODE_PREMUL;
    else                     cur_mode = MODE_SCALED;
  end

  always_comb begin
    seen_nz_d   = seen_nz_q;
    all_full_d  = all_full_q;
    exceeds_d   = exceeds_q;
    push_o      = 1'b0;
    cmd_o.kind  = CMD_ERR;
    cmd_o.mode  = cur_mode;
    cmd_o.index = in_i.pixel_index;
    cmd_o.pixel = in_i.pixel_in;
    if (accept) begin
      unique case (in_i.opcode)
        OP_START: begin
          seen_nz_d  = 1'b0;
          all_full_d = 1'b1;
          exceeds_d  = 1'b0;
        end
        OP_LOAD: begin
          push_o = 1'b1;
          if (bad_idx) begin
            cmd_o.kind = CMD_ERR;
          end else begin
            cmd_o.kind = CMD_WRITE;
            if (a_in != 8'd0)     seen_nz_d  = 1'b1;
            if (a_in != AlphaFull) all_full_d = 1'b0;
            if (in_i.pixel_in[7:0] > a_in || in_i.pixel_in[15:8] > a_in ||
                in_i.pixel_in[23:16] > a_in) exceeds_d = 1'b1;
          end
        end
        OP_READ: begin
          push_o     = 1'b1;
          cmd_o.kind = bad_idx ? CMD_ERR : CMD_READ;
        end
        OP_NONE: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_nz_q  <= 1'b0;
      all_full_q <= 1'b1;
      exceeds_q  <= 1'b0;
    end else begin
      seen_nz_q  <= seen_nz_d;
      all_full_q <= all_full_d;
      exceeds_q  <= exceeds_d;
    end
  end

endmodule

// ----- rtl/core/bgra_anp_queue.sv -----
// ----------------------------------------------------------------------------
// bgra_anp_queue
// Small in-order command queue between the front and the back end.
// ----------------------------------------------------------------------------
module bgra_anp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  bgra_anp_pkg::cmd_t    cmd_i,
  input  logic                  pop_i,
  output bgra_anp_pkg::cmd_t    cmd_o,
  output bgra_anp_pkg::q_stat_t stat_o
);
  import bgra_anp_pkg::*;

  cmd_t             entry_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;

  assign stat_o.full  = (count_q == (QPtrW+1)'(QDepth));
  assign stat_o.valid = (count_q != '0);
  assign cmd_o        = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.full |-> !push_i) else $error("push into a full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> stat_o.valid) else $error("pop from an empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= (QPtrW+1)'(QDepth)) else $error("queue count out of range");
`endif

endmodule

// ----- rtl/core/bgra_anp_back.sv -----
// ----------------------------------------------------------------------------
// bgra_anp_back
// Frame store and pixel normalizer: retires queued writes, reads and errors
// and holds each result in an output register until it is taken.
// ----------------------------------------------------------------------------
module bgra_anp_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  bgra_anp_pkg::q_stat_t  q_stat_i,
  input  bgra_anp_pkg::cmd_t     cmd_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output bgra_anp_pkg::out_item_t out_o
);
  import bgra_anp_pkg::*;

  logic [31:0]   mem [MaxPixels];
  logic [31:0]   rd_data_q;
  logic [31:0]   pix_q;
  logic [15:0]   prod_q [3];
  logic [7:0]    scaled [3];
  logic [15:0]   sum [3];
  mode_e         mode_q;
  out_item_t     out_q;
  back_state_e   state_q, state_d;
  logic          mem_we, mem_re, load_err, mul_en, fin_en;

  always_comb begin
    state_d     = state_q;
    pop_o       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    load_err    = 1'b0;
    mul_en      = 1'b0;
    fin_en      = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      BK_IDLE: begin
        if (q_stat_i.valid) begin
          pop_o = 1'b1;
          unique case (cmd_i.kind)
            CMD_WRITE: mem_we = 1'b1;
            CMD_READ: begin
              mem_re  = 1'b1;
              state_d = BK_READ;
            end
            CMD_ERR: begin
              load_err = 1'b1;
              state_d  = BK_OUT;
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        mul_en  = 1'b1;
        state_d = BK_MUL;
      end
      BK_MUL: begin
        fin_en  = 1'b1;
        state_d = BK_OUT;
      end
      BK_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= BK_IDLE;
    else         state_q <= state_d;
  end

  // single-port frame store
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[cmd_i.index] <= cmd_i.pixel;
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= mem[cmd_i.index];
      mode_q    <= cmd_i.mode;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      pix_q <= rd_data_q;
      for (int i = 0; i < 3; i++) begin
        prod_q[i] <= 16'(rd_data_q[8*i +: 8]) * 16'(rd_data_q[31:24]);
      end
    end
  end

  // x/255 for x up to 255*255: (x + 1 + (x >> 8)) >> 8, never above 16 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i]    = prod_q[i] + 16'd1 + {8'd0, prod_q[i][15:8]};
      scaled[i] = sum[i][15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_err) begin
      out_q.pixel_out   <= '0;
      out_q.alpha_mode  <= MODE_FORCED;
      out_q.index_error <= 1'b1;
    end else if (fin_en) begin
      out_q.alpha_mode  <= mode_q;
      out_q.index_error <= 1'b0;
      unique case (mode_q)
        MODE_FORCED: out_q.pixel_out <= {AlphaFull, pix_q[23:0]};
        MODE_SCALED: out_q.pixel_out <= {pix_q[31:24], scaled[2], scaled[1], scaled[0]};
        default:     out_q.pixel_out <= pix_q;
      endcase
    end
  end

  assign out_o = out_q;

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.index_error |->
      out_o.pixel_out == '0 && out_o.alpha_mode == MODE_FORCED)
    else $error("index error result carries data");
  a_forced_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.index_error && out_o.alpha_mode == MODE_FORCED |->
      out_o.pixel_out[31:24] == AlphaFull)
    else $error("forced-opaque result without full alpha");
  a_scaled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_o.index_error && out_o.alpha_mode == MODE_SCALED |->
      out_o.pixel_out[7:0] <= out_o.pixel_out[31:24] &&
      out_o.pixel_out[15:8] <= out_o.pixel_out[31:24] &&
      out_o.pixel_out[23:16] <= out_o.pixel_out[31:24])
    else $error("premultiplied channel above alpha");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_o))
    else $error("result dropped or changed while stalled");
`endif

endmodule

// ----- rtl/core/bgra_alpha_normalize_premultiply.sv -----
// ----------------------------------------------------------------------------
// bgra_alpha_normalize_premultiply
// Frame store for one BGRA8888 image with whole-image alpha normalization.
// ----------------------------------------------------------------------------
// Opcode 0 starts a new image, opcode 1 loads a pixel, opcode 2 reads a pixel
// back after the image-wide alpha decision (forced opaque, all opaque, already
// premultiplied, or premultiplied now as channel*alpha/255). An item is taken
// whenever the four-entry command queue has room. The back end works one
// command at a time: a load retires with no result, a read passes frame store
// read, channel multiply, scale by 1/255 and output hold, and a bad-index item
// goes straight to output hold, where a result waits for out_ready_i. Loads
// retire at one per cycle while no result is pending; no new command starts
// before it is taken, as set by the single-port 262144 x 32 frame store and
// the back-end sequencer. The store has no reset; reading a pixel never loaded
// gives undefined data. Width and height are written through the cfg channel,
// which is always ready, while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module bgra_alpha_normalize_premultiply (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  bgra_anp_pkg::in_item_t           in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output bgra_anp_pkg::out_item_t          out_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [bgra_anp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bgra_anp_pkg::DimW-1:0]    cfg_data_i
);
  import bgra_anp_pkg::*;

  q_stat_t q_stat;
  logic    push, pop;
  cmd_t    push_cmd, head_cmd;

  bgra_anp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  bgra_anp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (q_stat)
  );

  bgra_anp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
